/* rtl/cki_pkg.sv */
// ----------------------------------------------------------------------------
// cki_pkg
// Shared types and constants of the cyclic keyframe interpolator.
// ----------------------------------------------------------------------------
package cki_pkg;

    localparam int unsigned MAX_KEYS_DEF     = 16;
    localparam int unsigned NUM_CHANNELS_DEF = 14;
    localparam int unsigned QUEUE_DEPTH      = 4;
    localparam int unsigned DAY_MINUTES      = 1440;
    localparam int unsigned COUNT_W          = 5;

    localparam logic [1:0] ACT_WR_TIME = 2'd0;
    localparam logic [1:0] ACT_WR_VAL  = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    typedef enum logic [1:0] {
        K_WR_TIME = 2'd0,
        K_WR_VAL  = 2'd1,
        K_QUERY   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         key_index;
        logic [3:0]         channel_select;
        logic [31:0]        time_minutes;
        logic signed [23:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [23:0] out_value;
        logic [10:0]        out_time;
        logic               last;
    } t_res;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         key;
        logic [3:0]         ch;
        logic [31:0]        tm;
        logic signed [23:0] sv;
    } t_cmd;

endpackage

/* rtl/cki_ram.sv */
// ----------------------------------------------------------------------------
// cki_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cki_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/cki_fifo.sv */
// ----------------------------------------------------------------------------
// cki_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module cki_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/cki_front.sv */
// ----------------------------------------------------------------------------
// cki_front
// Accept input items, classify them and queue the ones that take effect.
// ----------------------------------------------------------------------------
module cki_front
    import cki_pkg::*;
#(
    parameter int unsigned MAX_KEYS     = MAX_KEYS_DEF,
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_item,
    output logic o_full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd             w_cmd;
    logic             w_keep;
    logic             w_empty;
    logic [$bits(t_cmd)-1:0] w_qdata;

    always_comb begin
        w_cmd.key = i_item.key_index;
        w_cmd.ch  = i_item.channel_select;
        w_cmd.tm  = i_item.time_minutes;
        w_cmd.sv  = i_item.sample_value;
        unique case (i_item.action)
            ACT_WR_TIME: begin
                w_cmd.kind = K_WR_TIME;
                w_keep     = (32'(i_item.key_index) < MAX_KEYS);
            end
            ACT_WR_VAL: begin
                w_cmd.kind = K_WR_VAL;
                w_keep     = (32'(i_item.key_index) < MAX_KEYS) &&
                             (32'(i_item.channel_select) < NUM_CHANNELS);
            end
            ACT_QUERY: begin
                w_cmd.kind = K_QUERY;
                w_keep     = 1'b1;
            end
            default: begin
                w_cmd.kind = K_QUERY;
                w_keep     = 1'b0;
            end
        endcase
    end

    cki_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_keep),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_qdata),
        .o_empty (w_empty)
    );

    assign o_cmd       = t_cmd'(w_qdata);
    assign o_cmd_valid = !w_empty;

endmodule

/* rtl/cki_back.sv */
// ----------------------------------------------------------------------------
// cki_back
// Execute queued writes and queries: reduce, search, divide, blend.
// ----------------------------------------------------------------------------
module cki_back
    import cki_pkg::*;
#(
    parameter int unsigned MAX_KEYS     = MAX_KEYS_DEF,
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    input  logic [COUNT_W-1:0] i_keyframe_count,
    output logic               o_res_push,
    output t_res               o_res,
    input  logic               i_res_full
);

    localparam int unsigned KW  = $clog2(MAX_KEYS);
    localparam int unsigned NW  = $clog2(MAX_KEYS + 1);
    localparam int unsigned CAW = $clog2(MAX_KEYS * NUM_CHANNELS);
    localparam int unsigned CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [11:0] DAY12 = 12'(DAY_MINUTES);
    // time mod 1440 = ((time >> 5) mod 45) * 32 + time[4:0]; ceil(2^33 / 45)
    localparam logic [26:0] DAY_SHR5  = 27'(DAY_MINUTES / 32);
    localparam logic [27:0] DIV45_MUL = 28'd190887436;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_MOD      = 14'b00000000000010,
        S_ONE_RD   = 14'b00000000000100,
        S_ONE_WT   = 14'b00000000001000,
        S_SRCH_RD  = 14'b00000000010000,
        S_SRCH_CMP = 14'b00000000100000,
        S_KA_RD    = 14'b00000001000000,
        S_KB_RD    = 14'b00000010000000,
        S_KB_WT    = 14'b00000100000000,
        S_DIV      = 14'b00001000000000,
        S_CA_RD    = 14'b00010000000000,
        S_CB_RD    = 14'b00100000000000,
        S_MUL      = 14'b01000000000000,
        S_EMIT     = 14'b10000000000000
    } t_state;

    t_state                r_state, n_state;
    logic [31:0]           r_rem;
    logic [4:0]            r_k;
    logic [21:0]           r_quo;
    logic [10:0]           r_q;
    logic [11:0]           r_qt;
    logic [NW-1:0]         r_lo, r_len;
    logic                  r_wrap;
    logic [KW-1:0]         r_ai, r_bi;
    logic [11:0]           r_at, r_den, r_drem;
    logic [16:0]           r_t;
    logic [3:0]            r_dcnt;
    logic                  r_zero;
    logic [10:0]           r_otime;
    logic [CW-1:0]         r_c;
    logic signed [23:0]    r_a;
    logic signed [42:0]    r_prod;

    logic                  w_key_we, w_chan_we;
    logic [KW-1:0]         w_key_raddr;
    logic [CAW-1:0]        w_chan_raddr, w_chan_waddr;
    logic [10:0]           w_key_rdata;
    logic [23:0]           w_chan_rdata;
    logic [NW-1:0]         w_n, w_half, w_mid;
    logic [54:0]           w_quo_prod;
    logic [26:0]           w_qx;
    logic [10:0]           w_qmod;
    logic [11:0]           w_bt, w_num, w_den;
    logic [12:0]           w_rem2;
    logic                  w_ge;
    logic signed [24:0]    w_diff;
    logic signed [42:0]    w_sum;
    logic                  w_last;

    assign w_n    = (32'(i_keyframe_count) > MAX_KEYS) ? NW'(MAX_KEYS)
                                                      : NW'(i_keyframe_count);
    assign w_half = r_len >> 1;
    assign w_mid  = r_lo + w_half;
    assign w_quo_prod = 55'(r_rem[31:5]) * 55'(DIV45_MUL);
    assign w_qx   = r_rem[31:5] - 27'(r_quo) * DAY_SHR5;
    assign w_qmod = {w_qx[5:0], r_rem[4:0]};
    assign w_bt   = 12'(w_key_rdata) + (r_wrap ? DAY12 : 12'd0);
    assign w_den  = w_bt - r_at;
    assign w_num  = (r_qt > r_at) ? ((r_qt - r_at > w_den) ? w_den : r_qt - r_at) : 12'd0;
    assign w_rem2 = {r_drem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_diff = 25'(signed'(w_chan_rdata)) - 25'(r_a);
    assign w_sum  = 43'(r_a) + ((r_prod + 43'sd32768) >>> 16);
    assign w_last = (r_c == CW'(NUM_CHANNELS - 1));

    assign w_key_we     = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == K_WR_TIME);
    assign w_chan_we    = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == K_WR_VAL);
    assign w_chan_waddr = CAW'(32'(i_cmd.key) * NUM_CHANNELS + 32'(i_cmd.ch));
    assign o_cmd_pop    = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        case (r_state)
            S_SRCH_RD: w_key_raddr = w_mid[KW-1:0];
            S_KA_RD:   w_key_raddr = r_ai;
            S_KB_RD:   w_key_raddr = r_bi;
            default:   w_key_raddr = '0;
        endcase
        if (r_state == S_CB_RD) begin
            w_chan_raddr = CAW'(32'(r_bi) * NUM_CHANNELS + 32'(r_c));
        end else begin
            w_chan_raddr = CAW'(32'(r_ai) * NUM_CHANNELS + 32'(r_c));
        end
    end

    cki_ram #(.WIDTH(11), .DEPTH(MAX_KEYS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (KW'(i_cmd.key)),
        .i_wdata (i_cmd.tm[10:0]),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    cki_ram #(.WIDTH(24), .DEPTH(MAX_KEYS * NUM_CHANNELS)) u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (w_chan_we),
        .i_waddr (w_chan_waddr),
        .i_wdata (i_cmd.sv),
        .i_raddr (w_chan_raddr),
        .o_rdata (w_chan_rdata)
    );

    assign o_res_push        = (r_state == S_EMIT) && !i_res_full;
    assign o_res.out_channel = 4'(r_c);
    assign o_res.out_value   = r_zero ? 24'sd0 : w_sum[23:0];
    assign o_res.out_time    = r_otime;
    assign o_res.last        = w_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_cmd_valid && i_cmd.kind == K_QUERY) n_state = S_MOD;
            S_MOD: begin
                if (r_k == '0) begin
                    if (w_n == NW'(1))      n_state = S_ONE_RD;
                    else if (w_n == '0)     n_state = S_CA_RD;
                    else                    n_state = S_SRCH_RD;
                end
            end
            S_ONE_RD:   n_state = S_ONE_WT;
            S_ONE_WT:   n_state = S_CA_RD;
            S_SRCH_RD:  n_state = (r_len == '0) ? S_KA_RD : S_SRCH_CMP;
            S_SRCH_CMP: n_state = S_SRCH_RD;
            S_KA_RD:    n_state = S_KB_RD;
            S_KB_RD:    n_state = S_KB_WT;
            S_KB_WT:    n_state = (w_bt <= r_at) ? S_CA_RD : S_DIV;
            S_DIV:      if (r_dcnt == '0) n_state = S_CA_RD;
            S_CA_RD:    n_state = S_CB_RD;
            S_CB_RD:    n_state = S_MUL;
            S_MUL:      n_state = S_EMIT;
            S_EMIT:     if (!i_res_full) n_state = w_last ? S_IDLE : S_CA_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rem <= i_cmd.tm;
                r_k   <= 5'd1;
            end
            S_MOD: begin
                r_quo <= w_quo_prod[54:33];
                r_k   <= r_k - 1'b1;
                if (r_k == '0) begin
                    r_q     <= w_qmod;
                    r_otime <= (w_n == '0) ? 11'd0 : w_qmod;
                    r_ai    <= '0;
                    r_bi    <= '0;
                    r_t     <= '0;
                    r_c     <= '0;
                    r_lo    <= '0;
                    r_len   <= w_n;
                    r_zero  <= (w_n == '0);
                end
            end
            S_ONE_WT: r_otime <= w_key_rdata;
            S_SRCH_RD: begin
                if (r_len == '0) begin
                    if (r_lo == '0 || r_lo == w_n) begin
                        r_wrap <= 1'b1;
                        r_ai   <= KW'(w_n - 1'b1);
                        r_bi   <= '0;
                    end else begin
                        r_wrap <= 1'b0;
                        r_ai   <= KW'(r_lo - 1'b1);
                        r_bi   <= KW'(r_lo);
                    end
                    r_qt <= (r_lo == '0) ? 12'(r_q) + DAY12 : 12'(r_q);
                end
            end
            S_SRCH_CMP: begin
                if (r_q < w_key_rdata) begin
                    r_len <= w_half;
                end else begin
                    r_lo  <= w_mid + 1'b1;
                    r_len <= r_len - w_half - 1'b1;
                end
            end
            S_KB_RD: r_at <= 12'(w_key_rdata);
            S_KB_WT: begin
                r_den  <= w_den;
                r_drem <= (w_num == w_den) ? 12'd0 : w_num;
                r_t    <= (w_bt <= r_at) ? 17'd0 : {16'd0, (w_num == w_den)};
                r_dcnt <= 4'd15;
            end
            S_DIV: begin
                r_drem <= w_ge ? 12'(w_rem2 - {1'b0, r_den}) : w_rem2[11:0];
                r_t    <= {r_t[15:0], w_ge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_CB_RD: r_a <= signed'(w_chan_rdata);
            S_MUL:   r_prod <= signed'({1'b0, r_t}) * w_diff;
            S_EMIT:  if (!i_res_full && !w_last) r_c <= r_c + 1'b1;
            default: ;
        endcase
    end

endmodule

/* rtl/cyclic_keyframe_interpolator.sv */
// ----------------------------------------------------------------------------
// cyclic_keyframe_interpolator
// Piecewise-linear keyframe table over a 24-hour day with wraparound.
// ----------------------------------------------------------------------------
// Keyframe and channel writes are executed as they leave the command queue.
// A query leaves the command queue, reduces the time modulo 1440 with a
// reciprocal multiplication, runs a binary search over the one-read-port
// key-time RAM (up to five steps plus a final read), reads the key pair and
// forms t with a bit-serial divider, then passes each channel through the
// channel RAM and the multiplier. Items queue in front of the engine and
// results queue behind it, so either side may stall on its own.
// ----------------------------------------------------------------------------
module cyclic_keyframe_interpolator
    import cki_pkg::*;
#(
    parameter int unsigned MAX_KEYS     = MAX_KEYS_DEF,
    parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  t_in                i_item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output t_res               o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    logic [COUNT_W-1:0]      r_keyframe_count;
    logic                    w_cmd_valid, w_cmd_pop, w_res_push, w_res_full;
    t_cmd                    w_cmd;
    t_res                    w_res;
    logic [$bits(t_res)-1:0] w_odata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keyframe_count <= '0;
        end else if (i_cfg_valid) begin
            r_keyframe_count <= i_cfg_data;
        end
    end

    cki_front #(.MAX_KEYS(MAX_KEYS), .NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    cki_back #(.MAX_KEYS(MAX_KEYS), .NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (w_cmd_valid),
        .i_cmd            (w_cmd),
        .o_cmd_pop        (w_cmd_pop),
        .i_keyframe_count (r_keyframe_count),
        .o_res_push       (w_res_push),
        .o_res            (w_res),
        .i_res_full       (w_res_full)
    );

    cki_fifo #(.WIDTH($bits(t_res)), .DEPTH(QUEUE_DEPTH)) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_odata),
        .o_empty (empty)
    );

    assign o_result = t_res'(w_odata);

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cyclic keyframe interpolator: fills the table,
// runs directed and random queries at several keyframe counts, and checks
// every channel result against an in-bench interpolation model.
// ----------------------------------------------------------------------------
module tb;
    import cki_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    t_in                i_item = '0;
    logic               full, empty;
    logic               pop = 1'b0;
    t_res               o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    cyclic_keyframe_interpolator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in               pending_items[$];
    t_res              expected_frames[$];
    logic [10:0]       key_minutes[16];
    logic signed [23:0] chan_vals[16][14];
    logic [4:0]        key_count = '0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                errors = 0;
    int                queries = 0;
    int                results_seen = 0;
    int                quiet = 0;

    function automatic t_in mk(logic [1:0] act, int key, int ch,
                               logic [31:0] tm, logic [31:0] sv);
        t_in it;
        it.action = act;
        it.key_index = 4'(key);
        it.channel_select = 4'(ch);
        it.time_minutes = tm;
        it.sample_value = sv[23:0];
        return it;
    endfunction

    function automatic void add_item(input t_in it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    task automatic interpolate(input t_in it);
        int          n, lo, len, half, mid, a_i, b_i;
        longint      q, qt, a_t, b_t, num, den, tq, av, bv, prod;
        t_res        r;
        case (it.action)
            ACT_WR_TIME: key_minutes[it.key_index] = it.time_minutes[10:0];
            ACT_WR_VAL: if (it.channel_select < NUM_CHANNELS_DEF)
                chan_vals[it.key_index][it.channel_select] = it.sample_value;
            ACT_QUERY: begin
                queries++;
                n = key_count > MAX_KEYS_DEF ? MAX_KEYS_DEF : key_count;
                q = longint'(it.time_minutes) % DAY_MINUTES;
                for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
                    r.out_channel = c[3:0];
                    r.last = (c == NUM_CHANNELS_DEF - 1);
                    r.out_value = '0;
                    r.out_time = q[10:0];
                    if (n == 0) begin
                        r.out_time = '0;
                    end else if (n == 1) begin
                        r.out_value = chan_vals[0][c];
                        r.out_time = key_minutes[0];
                    end else begin
                        lo = 0;
                        len = n;
                        while (len > 0) begin
                            half = len / 2;
                            mid = lo + half;
                            if (q < key_minutes[mid]) begin
                                len = half;
                            end else begin
                                lo = mid + 1;
                                len -= half + 1;
                            end
                        end
                        qt = q;
                        if (lo == 0 || lo == n) begin
                            a_i = n - 1;
                            b_i = 0;
                            a_t = longint'(key_minutes[a_i]);
                            b_t = longint'(key_minutes[0]) + DAY_MINUTES;
                            if (lo == 0) qt = q + DAY_MINUTES;
                        end else begin
                            a_i = lo - 1;
                            b_i = lo;
                            a_t = longint'(key_minutes[a_i]);
                            b_t = longint'(key_minutes[b_i]);
                        end
                        if (b_t <= a_t) begin
                            tq = 0;
                        end else begin
                            den = b_t - a_t;
                            num = qt > a_t ? qt - a_t : 0;
                            if (num > den) num = den;
                            tq = (num << 16) / den;
                        end
                        av = longint'(chan_vals[a_i][c]);
                        bv = longint'(chan_vals[b_i][c]);
                        prod = tq * (bv - av);
                        r.out_value = 24'(av + ((prod + 32768) >>> 16));
                    end
                    expected_frames.insert(expected_frames.size(), r);
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                interpolate(pending_items.pop_front());
                quiet = 0;
            end
            if (pending_items.size() > 0 && ($urandom % 100) >= send_idle_pct) begin
                push <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                quiet = 0;
                results_seen++;
                if (expected_frames.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %p", $realtime, o_result);
                end else if (o_result !== expected_frames[0]) begin
                    errors++;
                    $display("%0t mismatch expected %p actual %p", $realtime,
                             expected_frames[0], o_result);
                    void'(expected_frames.pop_front());
                end else begin
                    void'(expected_frames.pop_front());
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom % 100) >= recv_idle_pct;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        quiet++;
        if (i_cfg_valid && o_cfg_ready) quiet = 0;
        if (quiet >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic settle();
        wait (pending_items.size() == 0 && !push);
        wait (expected_frames.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [4:0] cnt);
        settle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        key_count = cnt;
    endtask

    task automatic random_items(input int cnt);
        int pick;
        for (int i = 0; i < cnt; i++) begin
            pick = $urandom % 100;
            if (pick < 45)
                add_item(mk(ACT_QUERY, $urandom, $urandom,
                    ($urandom % 2) ? $urandom : $urandom_range(0, 1439), $urandom));
            else if (pick < 75)
                add_item(mk(ACT_WR_VAL, $urandom, $urandom, $urandom, $urandom));
            else if (pick < 90)
                add_item(mk(ACT_WR_TIME, $urandom, $urandom,
                    ($urandom % 4) ? $urandom_range(0, 1439) : $urandom, $urandom));
            else
                add_item(mk(ACT_NONE, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    initial begin
        logic [4:0] cnt_pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_count(5'd0);
        add_item(mk(ACT_QUERY, 0, 0, 32'd0, 32'd0));
        add_item(mk(ACT_QUERY, 15, 15, 32'hFFFF_FFFF, 32'h00FF_FFFF));
        add_item(mk(ACT_NONE, 3, 3, 32'd100, 32'h0012_3456));

        // fill the whole table with sorted times and extreme values at the ends
        for (int k = 0; k < 16; k++) begin
            add_item(mk(ACT_WR_TIME, k, 0, 30 + 90 * k, 32'd0));
            for (int c = 0; c < 14; c++)
                add_item(mk(ACT_WR_VAL, k, c, 32'd0,
                    k == 0 ? 32'h0080_0000 : k == 15 ? 32'h007F_FFFF : $urandom));
        end
        add_item(mk(ACT_WR_VAL, 2, 14, 32'd0, 32'h0055_5555));
        add_item(mk(ACT_WR_VAL, 2, 15, 32'd0, 32'h00AA_AAAA));

        set_count(5'd1);
        add_item(mk(ACT_QUERY, 0, 0, 32'd700, 32'd0));
        set_count(5'd2);
        add_item(mk(ACT_QUERY, 0, 0, 32'd60, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd10, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd1439, 32'd0));
        set_count(5'd16);
        add_item(mk(ACT_QUERY, 0, 0, 32'd0, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd30, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd1380, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd1439, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'd1440 * 7 + 777, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 32'hFFFF_FFFF, 32'd0));
        // two keys at the same minute
        add_item(mk(ACT_WR_TIME, 5, 0, 30 + 90 * 4, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 30 + 90 * 4, 32'd0));
        add_item(mk(ACT_QUERY, 0, 0, 30 + 90 * 4 + 45, 32'd0));
        set_count(5'd31);
        add_item(mk(ACT_QUERY, 0, 0, 32'd1400, 32'd0));

        for (int m = 0; m < 3; m++) begin
            send_idle_pct = m == 0 ? 10 : m == 1 ? 51 : 0;
            recv_idle_pct = m == 0 ? 51 : m == 1 ? 10 : 0;
            for (int p = 0; p < 2; p++) begin
                cnt_pick = (m == 2 && p == 1) ? 5'd16 : 5'($urandom_range(0, 31));
                set_count(cnt_pick);
                if (m == 0 && p == 0) hold_req = 400;
                random_items(20);
            end
        end

        settle();
        $display("Covered %0d queries and %0d channel results over keyframe counts 0..31,",
                 queries, results_seen);
        $display("with both sides stalling and a long result back-pressure stretch.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
